// ===== hw/rtl/dtpg_pkg.sv =====
package dtpg_pkg;

   // Field widths of the pixel stream
   localparam int COL_W      = 10;
   localparam int ROW_W      = 9;
   localparam int COLOR_W    = 16;
   localparam int PHASE_W    = 16;

   // Cell tracking widths: index = coordinate / CELL_SIZE, offset = remainder
   localparam int COL_CELL_W = 5;
   localparam int ROW_CELL_W = 4;
   localparam int CELL_OFF_W = 6;
   localparam int CELL_SUM_W = 6;
   localparam int MOD9_W     = 4;

   // Pattern geometry
   localparam int BORDER_W   = 8;
   localparam int STRIPE_W   = 16;
   localparam int CELL_SIZE  = 40;
   localparam int CELL_MOD   = 9;
   localparam int PHASE_STEP = 19;
   localparam int NUM_BARS   = 8;
   localparam int BAR_W      = 3;

   // Stripe offset arithmetic: phase * 19 fits in 21 bits
   localparam int PROD_W     = PHASE_W + 5;
   localparam int RECIP_H_W  = 16;
   localparam int RECIP9_W   = 13;
   localparam logic [RECIP9_W-1:0] RECIP9 = RECIP9_W'((1 << PHASE_W) / CELL_MOD);

   // RGB565 colors
   localparam logic [COLOR_W-1:0] COLOR_WHITE  = 16'hFFFF;
   localparam logic [COLOR_W-1:0] COLOR_ORANGE = 16'hFBC0;
   localparam logic [COLOR_W-1:0] COLOR_DARK   = 16'h1082;

   // Scan position of one pixel request
   typedef struct packed {
      logic [COL_W-1:0]      col;
      logic [ROW_W-1:0]      row;
      logic [COL_CELL_W-1:0] col_cell;
      logic [ROW_CELL_W-1:0] row_cell;
      logic                  eol;
      logic                  eof;
   } dtpg_pos_type;

   // Values derived from the frame phase register
   typedef struct packed {
      logic [COL_W-1:0]  stripe_start;
      logic [MOD9_W-1:0] phase_mod9;
   } dtpg_phase_type;

   // Color of each vertical bar, left to right
   function automatic logic [COLOR_W-1:0] bar_color(input logic [BAR_W-1:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         3'd0:    c = 16'hF800;
         3'd1:    c = 16'h07E0;
         3'd2:    c = 16'h001F;
         3'd3:    c = 16'hFFFF;
         3'd4:    c = 16'h0000;
         3'd5:    c = 16'hFFE0;
         3'd6:    c = 16'h07FF;
         default: c = 16'hF81F;
      endcase
      return c;
   endfunction

   // True when the cell sum is a multiple of nine (sum never exceeds 45)
   function automatic logic cell_hit(input logic [CELL_SUM_W-1:0] s);
      logic hit;
      hit = 1'b0;
      for (int m = 0; m < 6; m++) begin
         if (s == CELL_SUM_W'(m * CELL_MOD)) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

// ===== hw/rtl/dtpg_req_if.sv =====
interface dtpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// ===== hw/rtl/dtpg_rsp_if.sv =====
interface dtpg_rsp_if import dtpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_color;
   logic [COL_W-1:0]   pixel_column;
   logic [ROW_W-1:0]   pixel_row;
   logic               end_of_line;
   logic               end_of_frame;

   modport source (output valid, output pixel_color, output pixel_column,
                   output pixel_row, output end_of_line, output end_of_frame,
                   input ready);
   modport sink   (input valid, input pixel_color, input pixel_column,
                   input pixel_row, input end_of_line, input end_of_frame,
                   output ready);
endinterface

// ===== hw/rtl/dtpg_phase.sv =====
module dtpg_phase import dtpg_pkg::*; #(
   parameter int H_PIXELS = 800
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [PHASE_W-1:0]   csr_wr_data,
   output dtpg_phase_type       phase,
   output logic                 busy
);

   // floor(2^PROD_W / H): quotient estimate is exact or one low
   localparam logic [RECIP_H_W-1:0] RECIP_H = RECIP_H_W'((1 << PROD_W) / H_PIXELS);
   localparam int PRODH_W = PROD_W + RECIP_H_W;
   localparam int PROD9_W = PHASE_W + RECIP9_W;

   logic [PHASE_W-1:0]   phase_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [RECIP_H_W-1:0] quot_h_ff, quot_h_in;
   logic [RECIP9_W-1:0]  quot9_ff, quot9_in;
   logic [COL_W+1:0]     rem_h_ff, rem_h_in;
   logic [MOD9_W:0]      rem9_ff, rem9_in;
   logic [COL_W-1:0]     stripe_ff, stripe_in;
   logic [MOD9_W-1:0]    mod9_ff, mod9_in;
   logic [1:0]           busy_ff, busy_in;
   logic [PRODH_W-1:0]   prod_h;
   logic [PROD9_W-1:0]   prod9;

   // phase * 19 on write
   assign prod_in = PROD_W'(csr_wr_data) * PROD_W'(PHASE_STEP);

   // reciprocal multiply for both quotients
   assign prod_h    = PRODH_W'(prod_ff) * PRODH_W'(RECIP_H);
   assign quot_h_in = prod_h[PRODH_W-1:PROD_W];
   assign prod9     = PROD9_W'(phase_ff) * PROD9_W'(RECIP9);
   assign quot9_in  = prod9[PROD9_W-1:PHASE_W];

   // remainders, below twice the divisor
   assign rem_h_in = (COL_W+2)'(prod_ff - PROD_W'(quot_h_ff) * PROD_W'(H_PIXELS));
   assign rem9_in  = (MOD9_W+1)'(phase_ff - PHASE_W'(quot9_ff) * PHASE_W'(CELL_MOD));

   // one correcting subtract
   assign stripe_in = (rem_h_ff >= (COL_W+2)'(H_PIXELS)) ?
                      COL_W'(rem_h_ff - (COL_W+2)'(H_PIXELS)) : COL_W'(rem_h_ff);
   assign mod9_in   = (rem9_ff >= (MOD9_W+1)'(CELL_MOD)) ?
                      MOD9_W'(rem9_ff - (MOD9_W+1)'(CELL_MOD)) : MOD9_W'(rem9_ff);

   // stall counter covering the three pipeline steps after a write
   always_comb begin
      if (csr_wr_en) begin
         busy_in = 2'd3;
      end else if (busy_ff != 2'd0) begin
         busy_in = busy_ff - 2'd1;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         prod_ff   <= '0;
         quot_h_ff <= '0;
         quot9_ff  <= '0;
         rem_h_ff  <= '0;
         rem9_ff   <= '0;
         stripe_ff <= '0;
         mod9_ff   <= '0;
         busy_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            phase_ff <= csr_wr_data;
            prod_ff  <= prod_in;
         end
         quot_h_ff <= quot_h_in;
         quot9_ff  <= quot9_in;
         rem_h_ff  <= rem_h_in;
         rem9_ff   <= rem9_in;
         stripe_ff <= stripe_in;
         mod9_ff   <= mod9_in;
         busy_ff   <= busy_in;
      end
   end

   assign phase.stripe_start = stripe_ff;
   assign phase.phase_mod9   = mod9_ff;
   assign busy               = (busy_ff != 2'd0);

endmodule

// ===== hw/rtl/dtpg_scan.sv =====
module dtpg_scan import dtpg_pkg::*; #(
   parameter int H_PIXELS = 800,
   parameter int V_PIXELS = 480
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         restart,
   input  logic         down_ready,
   output logic         pos_valid,
   output dtpg_pos_type pos
);

   localparam logic [COL_W-1:0]      LAST_COL  = COL_W'(H_PIXELS - 1);
   localparam logic [ROW_W-1:0]      LAST_ROW  = ROW_W'(V_PIXELS - 1);
   localparam logic [CELL_OFF_W-1:0] LAST_OFF  = CELL_OFF_W'(CELL_SIZE - 1);

   logic [COL_W-1:0]      col_ff, col_in, cur_col;
   logic [ROW_W-1:0]      row_ff, row_in, cur_row;
   logic [COL_CELL_W-1:0] ccell_ff, ccell_in, cur_ccell;
   logic [ROW_CELL_W-1:0] rcell_ff, rcell_in, cur_rcell;
   logic [CELL_OFF_W-1:0] coff_ff, coff_in, cur_coff;
   logic [CELL_OFF_W-1:0] roff_ff, roff_in, cur_roff;
   logic                  valid_ff, valid_in;
   dtpg_pos_type          pos_ff, pos_in;
   logic                  eol, eof;

   // position of this request: restart forces the top-left pixel
   always_comb begin
      cur_col   = restart ? '0 : col_ff;
      cur_row   = restart ? '0 : row_ff;
      cur_ccell = restart ? '0 : ccell_ff;
      cur_rcell = restart ? '0 : rcell_ff;
      cur_coff  = restart ? '0 : coff_ff;
      cur_roff  = restart ? '0 : roff_ff;
   end

   assign eol = (cur_col == LAST_COL);
   assign eof = eol && (cur_row == LAST_ROW);

   // column advance
   always_comb begin
      if (eol) begin
         col_in   = '0;
         coff_in  = '0;
         ccell_in = '0;
      end else begin
         col_in = cur_col + COL_W'(1);
         if (cur_coff == LAST_OFF) begin
            coff_in  = '0;
            ccell_in = cur_ccell + COL_CELL_W'(1);
         end else begin
            coff_in  = cur_coff + CELL_OFF_W'(1);
            ccell_in = cur_ccell;
         end
      end
   end

   // row advance at end of line, wrap at end of frame
   always_comb begin
      if (eof) begin
         row_in   = '0;
         roff_in  = '0;
         rcell_in = '0;
      end else if (eol) begin
         row_in = cur_row + ROW_W'(1);
         if (cur_roff == LAST_OFF) begin
            roff_in  = '0;
            rcell_in = cur_rcell + ROW_CELL_W'(1);
         end else begin
            roff_in  = cur_roff + CELL_OFF_W'(1);
            rcell_in = cur_rcell;
         end
      end else begin
         row_in   = cur_row;
         roff_in  = cur_roff;
         rcell_in = cur_rcell;
      end
   end

   always_comb begin
      pos_in.col      = cur_col;
      pos_in.row      = cur_row;
      pos_in.col_cell = cur_ccell;
      pos_in.row_cell = cur_rcell;
      pos_in.eol      = eol;
      pos_in.eof      = eof;
   end

   assign valid_in = accept ? 1'b1 : (down_ready ? 1'b0 : valid_ff);

   // scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         ccell_ff <= '0;
         rcell_ff <= '0;
         coff_ff  <= '0;
         roff_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            ccell_ff <= ccell_in;
            rcell_ff <= rcell_in;
            coff_ff  <= coff_in;
            roff_ff  <= roff_in;
         end
      end
   end

   // input stage register
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff <= pos_in;
      end
   end

   assign pos_valid = valid_ff;
   assign pos       = pos_ff;

endmodule

// ===== hw/rtl/dtpg_pixel.sv =====
module dtpg_pixel import dtpg_pkg::*; #(
   parameter int H_PIXELS = 800,
   parameter int V_PIXELS = 480
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           pos_valid,
   input  dtpg_pos_type   pos,
   input  dtpg_phase_type phase,
   output logic           out_ready,
   dtpg_rsp_if.source     rsp
);

   localparam logic [COL_W-1:0] RIGHT_EDGE  = COL_W'(H_PIXELS - BORDER_W);
   localparam logic [ROW_W-1:0] BOTTOM_EDGE = ROW_W'(V_PIXELS - BORDER_W);
   localparam int X8_W = COL_W + 3;

   logic                  valid_ff, valid_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic                  eol_ff, eof_ff;
   logic                  take;
   logic                  border, stripe, dark;
   logic [COL_W:0]        stripe_end;
   logic [CELL_SUM_W-1:0] cell_sum;
   logic [X8_W-1:0]       x8;
   logic [BAR_W-1:0]      bar_idx;

   assign out_ready = !valid_ff || rsp.ready;
   assign take      = pos_valid && out_ready;

   // overlays
   assign border = (pos.col < COL_W'(BORDER_W)) || (pos.col >= RIGHT_EDGE) ||
                   (pos.row < ROW_W'(BORDER_W)) || (pos.row >= BOTTOM_EDGE);

   assign stripe_end = {1'b0, phase.stripe_start} + (COL_W+1)'(STRIPE_W);
   assign stripe     = (pos.col >= phase.stripe_start) &&
                       ({1'b0, pos.col} < stripe_end);

   assign cell_sum = CELL_SUM_W'(pos.col_cell) + CELL_SUM_W'(pos.row_cell) +
                     CELL_SUM_W'(phase.phase_mod9);
   assign dark     = cell_hit(cell_sum);

   // bar index: number of bar boundaries at or left of 8*x
   assign x8 = {pos.col, 3'b000};
   always_comb begin
      bar_idx = '0;
      for (int k = 1; k < NUM_BARS; k++) begin
         if (x8 >= X8_W'(k * H_PIXELS)) bar_idx = bar_idx + BAR_W'(1);
      end
   end

   // priority select
   always_comb begin
      if (border) begin
         color_in = COLOR_WHITE;
      end else if (stripe) begin
         color_in = COLOR_ORANGE;
      end else if (dark) begin
         color_in = COLOR_DARK;
      end else begin
         color_in = bar_color(bar_idx);
      end
   end

   assign valid_in = take ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (take) begin
         color_ff <= color_in;
         col_ff   <= pos.col;
         row_ff   <= pos.row;
         eol_ff   <= pos.eol;
         eof_ff   <= pos.eof;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.pixel_color  = color_ff;
   assign rsp.pixel_column = col_ff;
   assign rsp.pixel_row    = row_ff;
   assign rsp.end_of_line  = eol_ff;
   assign rsp.end_of_frame = eof_ff;

endmodule

// ===== hw/rtl/display_test_pattern_generator_core.sv =====
// Color-bar test pattern source. Each accepted request on req_chan yields one
// RGB565 pixel on rsp_chan in raster order over H_PIXELS x V_PIXELS, with its
// column, row and end-of-line / end-of-frame flags; restart=1 rewinds the scan
// to the top-left pixel for that request. The block sustains one pixel per
// clock while rsp_chan.ready is high and no phase write is settling: a request
// passes a position register and then a result register. A write to the
// frame phase register (csr_wr_en / csr_wr_data) holds req_chan.ready low
// while the stripe column and the phase-mod-9 cell offset are worked out by a
// reciprocal-multiply pipeline; write it between frames.
module display_test_pattern_generator_core import dtpg_pkg::*; #(
   parameter int H_PIXELS = 800,
   parameter int V_PIXELS = 480
) (
   input  logic               clock,
   input  logic               reset,
   dtpg_req_if.sink           req_chan,
   dtpg_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [PHASE_W-1:0] csr_wr_data
);

   dtpg_phase_type phase;
   dtpg_pos_type   pos;
   logic           busy;
   logic           pos_valid;
   logic           out_ready;
   logic           accept;

   // phase register and derived offsets
   dtpg_phase #(
      .H_PIXELS (H_PIXELS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .phase       (phase),
      .busy        (busy)
   );

   // input handshake
   assign req_chan.ready = !busy && (!pos_valid || out_ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // scan position stage
   dtpg_scan #(
      .H_PIXELS (H_PIXELS),
      .V_PIXELS (V_PIXELS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (req_chan.restart),
      .down_ready (out_ready),
      .pos_valid  (pos_valid),
      .pos        (pos)
   );

   // color stage and result register
   dtpg_pixel #(
      .H_PIXELS (H_PIXELS),
      .V_PIXELS (V_PIXELS)
   ) u_pixel (
      .clock     (clock),
      .reset     (reset),
      .pos_valid (pos_valid),
      .pos       (pos),
      .phase     (phase),
      .out_ready (out_ready),
      .rsp       (rsp_chan)
   );

`ifndef SYNTHESIS
   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_frame |-> rsp_chan.end_of_line)
      else $error("end_of_frame without end_of_line");

   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pixel_column <= COL_W'(H_PIXELS - 1)) &&
                         (rsp_chan.pixel_row <= ROW_W'(V_PIXELS - 1)))
      else $error("pixel coordinate outside frame");

   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.restart |=> pos_valid && (pos.col == '0) && (pos.row == '0) &&
                                     (pos.col_cell == '0) && (pos.row_cell == '0))
      else $error("restart did not rewind scan");

   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_chan.ready)
      else $error("request taken while phase offsets settle");
`endif

endmodule
